/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file lgts_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lgts_pkg.sv */
// types and constants of the lda gibbs topic sampler
// no dependencies
package lgts_pkg;

    localparam int KIND_W     = 3;
    localparam int WORD_W     = 11;
    localparam int TIX_W      = 6;
    localparam int VALUE_W    = 32;
    localparam int PREV_W     = 7;
    localparam int RND_W      = 20;
    localparam int TOPIC_W    = 7;
    localparam int WEIGHT_W   = 48;
    localparam int PRIOR_W    = 24;
    localparam int VOCAB_W    = 21;
    localparam int NTOP_W     = 7;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam logic [RND_W-1:0] RANDOM_SCALE = 20'd1000000;

    localparam logic [KIND_W-1:0] KIND_LOAD_WT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_DOC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_TOT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DRAIN    = 3'd4;

    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_ETA    = 2'd1;
    localparam logic [1:0] REG_VOCAB  = 2'd2;
    localparam logic [1:0] REG_TOPICS = 2'd3;

    localparam logic [PRIOR_W-1:0] ALPHA_RESET  = 24'd6554;
    localparam logic [PRIOR_W-1:0] ETA_RESET    = 24'd6554;
    localparam logic [VOCAB_W-1:0] VOCAB_RESET  = 21'd1024;
    localparam logic [NTOP_W-1:0]  TOPICS_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_LOAD_WT,
        OP_LOAD_DOC,
        OP_LOAD_TOT,
        OP_SAMPLE,
        OP_BAD_WORD,
        OP_DRAIN
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  word;
        logic [TIX_W-1:0]   tix;
        logic [VALUE_W-1:0] value;
        logic [PREV_W-1:0]  prev;
        logic [RND_W-1:0]   rnd;
    } t_job;

    typedef struct packed {
        logic [PRIOR_W-1:0] alpha;
        logic [PRIOR_W-1:0] eta;
        logic [VOCAB_W-1:0] vocab;
        logic [NTOP_W-1:0]  topics;
    } t_cfg;

endpackage

/* hw/rtl/lgts_front.sv */
// front end: takes stream items, drops what does nothing, sorts the rest into jobs
// and holds them in a two-entry queue; depends on lgts_pkg
module lgts_front #(
    parameter int TOPICS = 64,
    parameter int VOCAB  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lgts_pkg::t_cfg                    i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lgts_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [lgts_pkg::KIND_W-1:0]       i_in_kind,
    output logic                              o_job_valid,
    output lgts_pkg::t_job                    o_job,
    input  logic                              i_job_pop
);

    localparam int QDEPTH = 2;

    logic [lgts_pkg::WORD_W-1:0]  word;
    logic [lgts_pkg::TIX_W-1:0]   tix;
    logic [lgts_pkg::VALUE_W-1:0] value;
    logic [lgts_pkg::PREV_W-1:0]  prev;
    logic [lgts_pkg::RND_W-1:0]   rnd;
    logic                         keep;
    logic                         bad;
    lgts_pkg::t_op                op;
    lgts_pkg::t_job               job;
    logic                         push;

    lgts_pkg::t_job r_q [QDEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign word  = i_in_data[10:0];
    assign tix   = i_in_data[16:11];
    assign value = i_in_data[48:17];
    assign prev  = i_in_data[55:49];
    assign rnd   = i_in_data[75:56];

    assign bad = (word == '0) || (21'(word) > i_cfg.vocab) || (32'(word) > VOCAB);

    always_comb begin
        keep = 1'b0;
        op   = lgts_pkg::OP_DRAIN;
        case (i_in_kind)
            lgts_pkg::KIND_LOAD_WT: begin
                op   = lgts_pkg::OP_LOAD_WT;
                keep = (32'(tix) < TOPICS) && (word != '0) && (32'(word) <= VOCAB);
            end
            lgts_pkg::KIND_LOAD_DOC: begin
                op   = lgts_pkg::OP_LOAD_DOC;
                keep = 32'(tix) < TOPICS;
            end
            lgts_pkg::KIND_LOAD_TOT: begin
                op   = lgts_pkg::OP_LOAD_TOT;
                keep = 32'(tix) < TOPICS;
            end
            lgts_pkg::KIND_SAMPLE: begin
                op   = bad ? lgts_pkg::OP_BAD_WORD : lgts_pkg::OP_SAMPLE;
                keep = 1'b1;
            end
            lgts_pkg::KIND_DRAIN: begin
                op   = lgts_pkg::OP_DRAIN;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        job.op    = op;
        job.word  = word;
        job.tix   = tix;
        job.value = value;
        job.prev  = prev;
        job.rnd   = rnd;
    end

    assign o_in_ready  = r_cnt != 2'(QDEPTH);
    assign push        = i_in_valid && o_in_ready && keep;
    assign o_job_valid = r_cnt != '0;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_job_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/lgts_div.sv */
// restoring divider, one quotient bit a cycle, saturating quotient
// no dependencies
module lgts_div #(
    parameter int NUMW = 98,
    parameter int TW   = 49,
    parameter int QW   = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [TW-1:0]   i_den,
    output logic            o_done,
    output logic [QW-1:0]   o_quot
);

    localparam int XW = (NUMW > TW + QW) ? NUMW : TW + QW;
    localparam int CW = $clog2(QW + 1);

    logic [XW-1:0] num_x;
    logic [XW-1:0] den_x;

    logic          r_busy;
    logic          r_done;
    logic [XW-1:0] r_rem;
    logic [XW-1:0] r_dsh;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;

    assign num_x  = XW'(i_num);
    assign den_x  = XW'(i_den);
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_quot <= (i_num == '0) ? '0 : '1;
                    r_done <= 1'b1;
                end else if (num_x >= (den_x << QW)) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= num_x;
                    r_dsh  <= den_x << (QW - 1);
                    r_quot <= '0;
                    r_cnt  <= CW'(QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_rem >= r_dsh) begin
                    r_rem  <= r_rem - r_dsh;
                    r_quot <= {r_quot[QW-2:0], 1'b1};
                end else begin
                    r_quot <= {r_quot[QW-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/lgts_back.sv */
// back end: count tables, per-topic weight pass, draw pass, assigned counters, drain
// depends on lgts_pkg and lgts_div
module lgts_back #(
    parameter int TOPICS      = 64,
    parameter int VOCAB       = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lgts_pkg::t_cfg                  i_cfg,
    input  logic                            i_job_valid,
    input  lgts_pkg::t_job                  i_job,
    output logic                            o_job_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lgts_pkg::TOPIC_W-1:0]    o_out_topic,
    output logic [lgts_pkg::VALUE_W-1:0]    o_out_count,
    output logic                            o_out_last,
    output logic                            o_out_bad
);

    localparam int KW    = $clog2(TOPICS);
    localparam int DEPTH = VOCAB * TOPICS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = lgts_pkg::WEIGHT_W;
    localparam int DW    = COUNT_WIDTH + 17;
    localparam int TW    = ((COUNT_WIDTH + 16 > 45) ? COUNT_WIDTH + 16 : 45) + 1;
    localparam int NUMW  = 2 * DW;
    localparam int SW    = WW + KW + 1;
    localparam int PW    = lgts_pkg::RND_W + SW;
    localparam int MW    = (NUMW > PW) ? NUMW : PW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_READ  = 12'b0000_0000_0010,
        S_PREP  = 12'b0000_0000_0100,
        S_MUL   = 12'b0000_0000_1000,
        S_DIV   = 12'b0000_0001_0000,
        S_WREAD = 12'b0000_0010_0000,
        S_WPREP = 12'b0000_0100_0000,
        S_ARD   = 12'b0000_1000_0000,
        S_AINC  = 12'b0001_0000_0000,
        S_DRD   = 12'b0010_0000_0000,
        S_DLOAD = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        MK_WEIGHT,
        MK_TARGET,
        MK_CUM
    } t_mk;

    // tables, no reset; only the valid bits r_asg_vld are reset
    logic [COUNT_WIDTH-1:0] r_wt_mem  [DEPTH];
    logic [COUNT_WIDTH-1:0] r_doc_mem [TOPICS];
    logic [COUNT_WIDTH-1:0] r_tot_mem [TOPICS];
    logic [WW-1:0]          r_wgt_mem [TOPICS];
    logic [COUNT_WIDTH-1:0] r_asg_mem [TOPICS];
    logic [TOPICS-1:0]      r_asg_vld;

    logic [COUNT_WIDTH-1:0] r_wt_rd;
    logic [COUNT_WIDTH-1:0] r_doc_rd;
    logic [COUNT_WIDTH-1:0] r_tot_rd;
    logic [WW-1:0]          r_wgt_rd;
    logic [COUNT_WIDTH-1:0] r_asg_rd;

    t_state                 r_state;
    t_mk                    r_mk;
    lgts_pkg::t_job         r_job;
    logic [KW-1:0]          r_k;
    logic [KW-1:0]          r_chosen;
    logic [AW-1:0]          r_base;
    logic [44:0]            r_veta;
    logic [SW-1:0]          r_sum;
    logic [MW-1:0]          r_cum;
    logic [MW-1:0]          r_target;
    logic [MW-1:0]          r_ma;
    logic [DW-1:0]          r_mb;
    logic [MW-1:0]          r_acc;
    logic [TW-1:0]          r_den;
    logic                   r_out_valid;
    logic [lgts_pkg::TOPIC_W-1:0] r_out_topic;
    logic [lgts_pkg::VALUE_W-1:0] r_out_count;
    logic                   r_out_last;
    logic                   r_out_bad;

    logic [KW:0]            act_n;
    logic [KW-1:0]          last_k;
    logic                   at_last;
    logic                   prev_hit;
    logic [COUNT_WIDTH-1:0] d_cnt;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic [DW-1:0]          dval;
    logic [DW-1:0]          wval;
    logic [TW-1:0]          tval;
    logic [31:0]            row;
    logic [AW-1:0]          ld_addr;
    logic [MW-1:0]          n_cum;
    logic [SW-1:0]          n_sum;
    logic [COUNT_WIDTH-1:0] asg_cur;
    logic [COUNT_WIDTH-1:0] asg_inc;
    logic [KW-1:0]          asg_raddr;
    logic                   div_start;
    logic                   div_done;
    logic [WW-1:0]          div_quot;

    // topics in use clamped to 1..TOPICS
    always_comb begin
        if (i_cfg.topics == '0) begin
            act_n = (KW+1)'(1);
        end else if (32'(i_cfg.topics) > TOPICS) begin
            act_n = (KW+1)'(TOPICS);
        end else begin
            act_n = (KW+1)'(i_cfg.topics);
        end
    end

    assign last_k  = KW'(act_n - (KW+1)'(1));
    assign at_last = r_k == last_k;

    // excluded topic counts taken down by one, floored at zero
    assign prev_hit = (7'(r_k) + 7'd1) == r_job.prev;
    assign d_cnt = (prev_hit && r_doc_rd != '0) ? r_doc_rd - COUNT_WIDTH'(1) : r_doc_rd;
    assign w_cnt = (prev_hit && r_wt_rd != '0) ? r_wt_rd - COUNT_WIDTH'(1) : r_wt_rd;
    assign dval  = DW'({d_cnt, 16'b0}) + DW'(i_cfg.alpha);
    assign wval  = DW'({w_cnt, 16'b0}) + DW'(i_cfg.eta);
    assign tval  = TW'({r_tot_rd, 16'b0}) + TW'(r_veta);

    assign row     = (32'(i_job.word) - 32'd1) * 32'(TOPICS);
    assign ld_addr = AW'(row + 32'(i_job.tix));
    assign n_cum   = r_cum + r_acc;
    assign n_sum   = r_sum + SW'(div_quot);
    assign asg_cur = r_asg_vld[r_chosen] ? r_asg_rd : '0;
    assign asg_inc = (asg_cur == '1) ? asg_cur : asg_cur + COUNT_WIDTH'(1);
    assign asg_raddr = (r_state == S_ARD) ? r_chosen : r_k;

    assign div_start = (r_state == S_MUL) && (r_mb == '0) && (r_mk == MK_WEIGHT);
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_topic = r_out_topic;
    assign o_out_count = r_out_count;
    assign o_out_last  = r_out_last;
    assign o_out_bad   = r_out_bad;

    lgts_div #(
        .NUMW (NUMW),
        .TW   (TW),
        .QW   (WW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc[NUMW-1:0]),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            case (i_job.op)
                lgts_pkg::OP_LOAD_WT:  r_wt_mem[ld_addr] <= COUNT_WIDTH'(i_job.value);
                lgts_pkg::OP_LOAD_DOC: r_doc_mem[i_job.tix[KW-1:0]] <= COUNT_WIDTH'(i_job.value);
                lgts_pkg::OP_LOAD_TOT: r_tot_mem[i_job.tix[KW-1:0]] <= COUNT_WIDTH'(i_job.value);
                default: ;
            endcase
        end
        if (r_state == S_READ) begin
            r_wt_rd  <= r_wt_mem[r_base + AW'(r_k)];
            r_doc_rd <= r_doc_mem[r_k];
            r_tot_rd <= r_tot_mem[r_k];
        end
        if (r_state == S_DIV && div_done) begin
            r_wgt_mem[r_k] <= div_quot;
        end
        if (r_state == S_WREAD) begin
            r_wgt_rd <= r_wgt_mem[r_k];
        end
        if (r_state == S_ARD || r_state == S_DRD) begin
            r_asg_rd <= r_asg_mem[asg_raddr];
        end
        if (r_state == S_AINC) begin
            r_asg_mem[r_chosen] <= asg_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_asg_vld   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        case (i_job.op)
                            lgts_pkg::OP_SAMPLE: begin
                                r_base  <= AW'(row);
                                r_veta  <= {24'b0, i_cfg.vocab} * {21'b0, i_cfg.eta};
                                r_k     <= '0;
                                r_sum   <= '0;
                                r_state <= S_READ;
                            end
                            lgts_pkg::OP_BAD_WORD: begin
                                r_out_topic <= '0;
                                r_out_count <= '0;
                                r_out_last  <= 1'b1;
                                r_out_bad   <= 1'b1;
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end
                            lgts_pkg::OP_DRAIN: begin
                                r_k     <= '0;
                                r_state <= S_DRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_ma    <= MW'(dval);
                    r_mb    <= wval;
                    r_acc   <= '0;
                    r_den   <= tval;
                    r_mk    <= MK_WEIGHT;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // shift-add, stops once the multiplier bits run out
                    if (r_mb != '0) begin
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end else begin
                        case (r_mk)
                            MK_WEIGHT: begin
                                r_state <= S_DIV;
                            end
                            MK_TARGET: begin
                                r_target <= r_acc;
                                r_k      <= '0;
                                r_cum    <= '0;
                                r_state  <= S_WREAD;
                            end
                            MK_CUM: begin
                                r_cum <= n_cum;
                                if (n_cum > r_target) begin
                                    r_chosen <= r_k;
                                    r_state  <= S_ARD;
                                end else if (at_last) begin
                                    r_chosen <= last_k;
                                    r_state  <= S_ARD;
                                end else begin
                                    r_k     <= r_k + KW'(1);
                                    r_state <= S_WREAD;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_sum <= n_sum;
                        if (at_last) begin
                            r_ma    <= MW'(n_sum);
                            r_mb    <= DW'(r_job.rnd);
                            r_acc   <= '0;
                            r_mk    <= MK_TARGET;
                            r_state <= S_MUL;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_WREAD: begin
                    r_state <= S_WPREP;
                end
                S_WPREP: begin
                    r_ma    <= MW'(r_wgt_rd);
                    r_mb    <= DW'(lgts_pkg::RANDOM_SCALE);
                    r_acc   <= '0;
                    r_mk    <= MK_CUM;
                    r_state <= S_MUL;
                end
                S_ARD: begin
                    r_state <= S_AINC;
                end
                S_AINC: begin
                    r_asg_vld[r_chosen] <= 1'b1;
                    r_out_topic <= 7'(r_chosen) + 7'd1;
                    r_out_count <= '0;
                    r_out_last  <= 1'b1;
                    r_out_bad   <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_DRD: begin
                    r_state <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_out_topic <= 7'(r_k) + 7'd1;
                    r_out_count <= r_asg_vld[r_k] ? 32'(r_asg_rd) : '0;
                    r_out_last  <= at_last;
                    r_out_bad   <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_job.op == lgts_pkg::OP_DRAIN && !r_out_last) begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_DRD;
                        end else begin
                            if (r_job.op == lgts_pkg::OP_DRAIN) begin
                                r_asg_vld <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/lda_gibbs_topic_sampler_core.sv */
// top level of the lda gibbs topic sampler: config registers, front end, back end
// depends on lgts_pkg, lgts_front, lgts_back
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/tready         tdata word..random_value, tuser kind
//  m_axis    out        m_axis_tvalid/tready         tdata topic,count, tlast, tuser bad
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// loads are done in the back end's idle state, a bad word goes straight to the output wait
// a sample's time depends on the number of active topics, the drawn topic and the bit
// length of the word-topic term; it is set by the shift-add multiplier and the divider
// that every topic weight passes through
// a drain reads each topic's counter, loads its result and waits until it is taken
// no clearing pass after reset; until it is full, the two-entry queue keeps taking
// items while the back end is busy or its result is stalled
module lda_gibbs_topic_sampler_core #(
    parameter int TOPICS      = 64,
    parameter int VOCAB       = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // word[10:0], topic_index[16:11], count_value[48:17], previous_topic[55:49],
    // random_value[75:56], zero [79:76]
    input  logic [79:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chosen_topic[6:0], new_count[38:7], zero [39]
    output logic [39:0] m_axis_tdata,
    // bad_word[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    lgts_pkg::t_cfg r_cfg;
    lgts_pkg::t_job job;
    logic           job_valid;
    logic           job_pop;
    logic [6:0]     out_topic;
    logic [31:0]    out_count;
    logic           out_bad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha  <= lgts_pkg::ALPHA_RESET;
            r_cfg.eta    <= lgts_pkg::ETA_RESET;
            r_cfg.vocab  <= lgts_pkg::VOCAB_RESET;
            r_cfg.topics <= lgts_pkg::TOPICS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lgts_pkg::REG_ALPHA:  r_cfg.alpha  <= i_cfg_data;
                lgts_pkg::REG_ETA:    r_cfg.eta    <= i_cfg_data;
                lgts_pkg::REG_VOCAB:  r_cfg.vocab  <= i_cfg_data[20:0];
                lgts_pkg::REG_TOPICS: r_cfg.topics <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    lgts_front #(
        .TOPICS (TOPICS),
        .VOCAB  (VOCAB)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    lgts_back #(
        .TOPICS      (TOPICS),
        .VOCAB       (VOCAB),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_topic (out_topic),
        .o_out_count (out_count),
        .o_out_last  (m_axis_tlast),
        .o_out_bad   (out_bad)
    );

    assign m_axis_tdata = {1'b0, out_count, out_topic};
    assign m_axis_tuser = out_bad;

endmodule

/* hw/rtl/lgts_checker.sv */
// port-level checks of the topic sampler, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module lgts_checker #(
    parameter int TOPICS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
    `ASSERT_IMPLY(a_bad_shape, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[38:0] == 39'd0), "bad word result not a lone zero result")
    `ASSERT_IMPLY(a_count_drain, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[38:7] != 32'd0), !m_axis_tuser[0], "count shown on a bad word result")
    `ASSERT_IMPLY(a_topic_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[6:0] <= 7'(TOPICS), "topic beyond built count")

endmodule

bind lda_gibbs_topic_sampler_core lgts_checker #(
    .TOPICS (TOPICS)
) u_lgts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/testbench.sv */
// self-checking testbench for lda_gibbs_topic_sampler_core: loads count tables,
// draws topics and drains the per-topic tallies under random stalls on both streams
// depends on lgts_pkg and the rtl of lda_gibbs_topic_sampler_core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TOPICS = 64;
    localparam int NUM_WORDS = 1024;
    // only this many topics are loaded, so draws stay within them
    localparam int LOADED_TOPICS = 16;
    localparam int IDLE_LIMIT = 60000;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD = 3000;
    localparam logic [lgts_pkg::KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [lgts_pkg::KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [lgts_pkg::KIND_W-1:0] KIND_SPARE_HI  = 3'd7;
    localparam logic [lgts_pkg::WEIGHT_W-1:0] WEIGHT_SAT = '1;
    localparam logic [19:0] RND_TOP = 20'd999999;

    typedef struct packed {
        logic [lgts_pkg::KIND_W-1:0]  kind;
        logic [lgts_pkg::WORD_W-1:0]  word;
        logic [lgts_pkg::TIX_W-1:0]   tix;
        logic [lgts_pkg::VALUE_W-1:0] value;
        logic [lgts_pkg::PREV_W-1:0]  prev;
        logic [lgts_pkg::RND_W-1:0]   rnd;
    } t_request;

    typedef struct packed {
        logic [lgts_pkg::TOPIC_W-1:0] topic;
        logic [31:0]                  count;
        logic                         last;
        logic                         bad;
    } t_draw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    lda_gibbs_topic_sampler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow of the block state
    logic [31:0]                  word_topic_tab [int];
    logic [31:0]                  doc_tab [NUM_TOPICS];
    logic [31:0]                  total_tab [NUM_TOPICS];
    logic [31:0]                  tally [NUM_TOPICS];
    logic [lgts_pkg::PRIOR_W-1:0] alpha_cfg = lgts_pkg::ALPHA_RESET;
    logic [lgts_pkg::PRIOR_W-1:0] eta_cfg = lgts_pkg::ETA_RESET;
    logic [lgts_pkg::VOCAB_W-1:0] vocab_cfg = lgts_pkg::VOCAB_RESET;
    logic [lgts_pkg::NTOP_W-1:0]  topics_cfg = lgts_pkg::TOPICS_RESET;

    t_request pending_requests[$];
    t_draw    expected_draws[$];
    int       loaded_words[$];
    int       fail_count = 0;
    int       draws_seen = 0;

    t_request cur_req;
    t_request next_req;
    int       in_gap = 0;
    int       out_hold = 0;
    bit       long_hold_done = 0;
    int       idle_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int active_topics();
        if (topics_cfg == 0) return 1;
        if (topics_cfg > NUM_TOPICS) return NUM_TOPICS;
        return int'(topics_cfg);
    endfunction

    function automatic logic [47:0] topic_weight(logic [31:0] d, logic [31:0] w,
                                                 logic [31:0] t);
        logic [127:0] num;
        logic [127:0] den;
        num = ((128'(d) << 16) + 128'(alpha_cfg)) * ((128'(w) << 16) + 128'(eta_cfg));
        den = (128'(t) << 16) + 128'(vocab_cfg) * 128'(eta_cfg);
        if (den == 0) return (num == 0) ? 48'd0 : WEIGHT_SAT;
        if (num >= (den << 48)) return WEIGHT_SAT;
        return 48'(num / den);
    endfunction

    // updates the shadow state for one accepted request and queues its draws
    task automatic predict_draws(t_request q);
        int           n;
        int           chosen;
        logic [47:0]  wgt [NUM_TOPICS];
        logic [63:0]  sum;
        logic [63:0]  cum;
        logic [127:0] target;
        logic [31:0]  w;
        logic [31:0]  d;
        t_draw        r;
        n = active_topics();
        r = '0;
        case (q.kind)
            lgts_pkg::KIND_LOAD_WT: begin
                if (q.word >= 1 && q.word <= NUM_WORDS)
                    word_topic_tab[(int'(q.word) - 1) * NUM_TOPICS + int'(q.tix)] = q.value;
            end
            lgts_pkg::KIND_LOAD_DOC: doc_tab[q.tix] = q.value;
            lgts_pkg::KIND_LOAD_TOT: total_tab[q.tix] = q.value;
            lgts_pkg::KIND_SAMPLE: begin
                r.last = 1'b1;
                if (q.word == 0 || q.word > vocab_cfg || q.word > NUM_WORDS) begin
                    r.bad = 1'b1;
                end else begin
                    sum = 0;
                    for (int k = 0; k < n; k++) begin
                        w = word_topic_tab[(int'(q.word) - 1) * NUM_TOPICS + k];
                        d = doc_tab[k];
                        // the token's own earlier topic is taken out, floored at zero
                        if (k + 1 == int'(q.prev)) begin
                            if (w != 0) w--;
                            if (d != 0) d--;
                        end
                        wgt[k] = topic_weight(d, w, total_tab[k]);
                        sum += 64'(wgt[k]);
                    end
                    target = 128'(q.rnd) * 128'(sum);
                    chosen = n;
                    cum = 0;
                    for (int k = 0; k < n; k++) begin
                        cum += 64'(wgt[k]);
                        if (128'(cum) * 128'(lgts_pkg::RANDOM_SCALE) > target) begin
                            chosen = k + 1;
                            break;
                        end
                    end
                    if (tally[chosen - 1] != '1) tally[chosen - 1]++;
                    r.topic = lgts_pkg::TOPIC_W'(chosen);
                end
                expected_draws.push_back(r);
            end
            lgts_pkg::KIND_DRAIN: begin
                for (int k = 0; k < n; k++) begin
                    r.topic = lgts_pkg::TOPIC_W'(k + 1);
                    r.count = tally[k];
                    r.last = (k + 1 == n);
                    r.bad = 1'b0;
                    expected_draws.push_back(r);
                end
                for (int k = 0; k < NUM_TOPICS; k++) tally[k] = 0;
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_draws(cur_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    next_req = pending_requests.pop_front();
                    cur_req <= next_req;
                    s_axis_tdata <= {4'b0, next_req.rnd, next_req.prev, next_req.value,
                                     next_req.tix, next_req.word};
                    s_axis_tuser <= next_req.kind;
                    s_axis_tvalid <= 1'b1;
                    case ($urandom_range(0, 99)) inside
                        [0:59]:  in_gap <= 0;
                        [60:94]: in_gap <= $urandom_range(1, 3);
                        default: in_gap <= $urandom_range(20, 80);
                    endcase
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                draws_seen <= draws_seen + 1;
                if (expected_draws.size() == 0) begin
                    $error("unexpected result topic=%0d", m_axis_tdata[6:0]);
                    fail_count++;
                end else begin
                    t_draw e;
                    e = expected_draws.pop_front();
                    if (m_axis_tdata[6:0] !== e.topic) begin
                        $error("chosen_topic exp %0d got %0d", e.topic, m_axis_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[38:7] !== e.count) begin
                        $error("new_count exp %0d got %0d", e.count, m_axis_tdata[38:7]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last_of_run exp %0b got %0b", e.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== e.bad) begin
                        $error("bad_word exp %0b got %0b", e.bad, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold <= out_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && draws_seen >= 20) begin
                // one long hold-off so the input queue backs up
                long_hold_done <= 1'b1;
                out_hold <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:1]:   begin out_hold <= $urandom_range(50, 300); m_axis_tready <= 1'b0; end
                    [2:24]:  begin out_hold <= $urandom_range(0, 3); m_axis_tready <= 1'b0; end
                    default: m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // watchdog on cycles without any handshake on the input, output or config port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_req(logic [2:0] kind, int word, int tix, logic [31:0] value,
                           int prev, int rnd);
        t_request q;
        q.kind = kind;
        q.word = lgts_pkg::WORD_W'(word);
        q.tix = lgts_pkg::TIX_W'(tix);
        q.value = value;
        q.prev = lgts_pkg::PREV_W'(prev);
        q.rnd = lgts_pkg::RND_W'(rnd);
        pending_requests.push_back(q);
    endtask

    function automatic logic [31:0] rand_count();
        case ($urandom_range(0, 9)) inside
            [0:4]:   return $urandom_range(0, 15);
            [5:7]:   return $urandom_range(0, 5000);
            8:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_draw();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return int'(RND_TOP);
            2:       return $urandom_range(0, 20'hFFFFF);
            default: return $urandom_range(0, int'(RND_TOP));
        endcase
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            lgts_pkg::REG_ALPHA: alpha_cfg = data;
            lgts_pkg::REG_ETA:   eta_cfg = data;
            lgts_pkg::REG_VOCAB: vocab_cfg = data[lgts_pkg::VOCAB_W-1:0];
            default:             topics_cfg = data[lgts_pkg::NTOP_W-1:0];
        endcase
    endtask

    task automatic set_config(logic [23:0] a, logic [23:0] e, logic [23:0] v,
                              logic [23:0] t);
        write_reg(lgts_pkg::REG_ALPHA, a);
        write_reg(lgts_pkg::REG_ETA, e);
        write_reg(lgts_pkg::REG_VOCAB, v);
        write_reg(lgts_pkg::REG_TOPICS, t);
    endtask

    task automatic wait_quiet();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_draws.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int good_word();
        return loaded_words[$urandom_range(0, loaded_words.size() - 1)];
    endfunction

    function automatic int bad_word();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return $urandom_range(NUM_WORDS + 1, 2047);
            default: return (vocab_cfg < NUM_WORDS) ?
                            $urandom_range(int'(vocab_cfg) + 1, NUM_WORDS) : 2047;
        endcase
    endfunction

    function automatic bit word_is_loaded(int w);
        foreach (loaded_words[i]) if (loaded_words[i] == w) return 1;
        return 0;
    endfunction

    task automatic random_mix(int count);
        int n;
        n = active_topics();
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 99)) inside
                [0:59]:
                    add_req(lgts_pkg::KIND_SAMPLE, good_word(), $urandom_range(0, 63),
                            $urandom,
                            $urandom_range(0, 1) ? $urandom_range(0, n + 1)
                                                 : $urandom_range(0, 127),
                            rand_draw());
                [60:66]:
                    add_req(lgts_pkg::KIND_SAMPLE, bad_word(), $urandom_range(0, 63),
                            $urandom, $urandom_range(0, 127), $urandom_range(0, 20'hFFFFF));
                [67:84]: begin
                    logic [2:0] k;
                    int         w;
                    k = lgts_pkg::KIND_W'($urandom_range(0, 2));
                    w = ($urandom_range(0, 5) == 0) ? bad_word() : good_word();
                    if (w >= 1 && w <= NUM_WORDS && k == lgts_pkg::KIND_LOAD_WT &&
                        !word_is_loaded(w))
                        w = 0;
                    add_req(k, w, $urandom_range(0, 63), rand_count(),
                            $urandom_range(0, 127), $urandom_range(0, 20'hFFFFF));
                end
                [85:90]:
                    add_req(lgts_pkg::KIND_DRAIN, $urandom_range(0, 2047),
                            $urandom_range(0, 63), $urandom, $urandom_range(0, 127),
                            $urandom_range(0, 20'hFFFFF));
                default:
                    add_req(lgts_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                            $urandom_range(0, 2047), $urandom_range(0, 63), $urandom,
                            $urandom_range(0, 127), $urandom_range(0, 20'hFFFFF));
            endcase
        end
        add_req(lgts_pkg::KIND_DRAIN, 0, 0, 0, 0, 0);
    endtask

    initial begin
        for (int k = 0; k < NUM_TOPICS; k++) tally[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(lgts_pkg::REG_TOPICS, 24'(LOADED_TOPICS));

        // every entry that a draw can read is loaded first
        loaded_words = '{1, NUM_WORDS};
        for (int k = 0; k < LOADED_TOPICS; k++) begin
            add_req(lgts_pkg::KIND_LOAD_DOC, 0, k, rand_count(), 0, 0);
            add_req(lgts_pkg::KIND_LOAD_TOT, 0, k, rand_count(), 0, 0);
        end
        foreach (loaded_words[i])
            for (int k = 0; k < LOADED_TOPICS; k++)
                add_req(lgts_pkg::KIND_LOAD_WT, loaded_words[i], k, rand_count(), 0, 0);

        // directed corner cases
        add_req(lgts_pkg::KIND_SAMPLE, 0, 0, 0, 0, 500000);
        add_req(lgts_pkg::KIND_SAMPLE, 2047, 63, '1, 127, 20'hFFFFF);
        add_req(lgts_pkg::KIND_SAMPLE, NUM_WORDS + 1, 0, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, NUM_WORDS, 0, 0, 1, int'(RND_TOP));
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, LOADED_TOPICS, 20'hFFFFF);
        add_req(lgts_pkg::KIND_SAMPLE, NUM_WORDS, 0, 0, 127, 500000);
        add_req(lgts_pkg::KIND_LOAD_WT, 0, 5, '1, 0, 0);
        add_req(lgts_pkg::KIND_LOAD_WT, NUM_WORDS + 1, 5, '1, 0, 0);
        add_req(lgts_pkg::KIND_LOAD_DOC, 0, LOADED_TOPICS - 1, '1, 0, 0);
        add_req(lgts_pkg::KIND_LOAD_WT, 1, LOADED_TOPICS - 1, '1, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, LOADED_TOPICS, 999000);
        // excluded topic whose counts are already zero
        add_req(lgts_pkg::KIND_LOAD_WT, 1, 2, 0, 0, 0);
        add_req(lgts_pkg::KIND_LOAD_DOC, 0, 2, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, 3, 123456);
        add_req(lgts_pkg::KIND_LOAD_TOT, 0, 0, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, NUM_WORDS, 0, 0, LOADED_TOPICS + 1, 1);
        add_req(KIND_SPARE_LO, 1, 1, 1, 1, 1);
        add_req(KIND_SPARE_MID, 2047, 63, '1, 127, 20'hFFFFF);
        add_req(KIND_SPARE_HI, 0, 0, 0, 0, 0);
        add_req(lgts_pkg::KIND_DRAIN, 0, 0, 0, 0, 0);
        random_mix(25);
        wait_quiet();

        // largest priors, a single word and a single topic
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1);
        random_mix(8);
        wait_quiet();

        // zero priors: zero-weight and zero-denominator draws
        set_config(24'd0, 24'd0, 24'd1048576, 24'd8);
        for (int k = 0; k < 8; k++) add_req(lgts_pkg::KIND_LOAD_DOC, 0, k, 0, 0, 0);
        for (int k = 0; k < 4; k++) add_req(lgts_pkg::KIND_LOAD_TOT, 0, k, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, NUM_WORDS, 0, 0, 0, int'(RND_TOP));
        add_req(lgts_pkg::KIND_LOAD_DOC, 0, 3, 7, 0, 0);
        add_req(lgts_pkg::KIND_LOAD_WT, 1, 3, 9, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, 0, 0);
        add_req(lgts_pkg::KIND_SAMPLE, 1, 0, 0, 4, 700000);
        random_mix(8);
        wait_quiet();

        set_config(24'($urandom), 24'($urandom), 24'd700, 24'd13);
        random_mix(10);
        wait_quiet();

        // topic count of zero behaves as one
        write_reg(lgts_pkg::REG_TOPICS, 24'd0);
        random_mix(5);
        wait_quiet();

        set_config(lgts_pkg::ALPHA_RESET, 24'($urandom_range(1, 100000)), 24'd1023,
                   24'(LOADED_TOPICS));
        random_mix(6);
        wait_quiet();

        if (fail_count == 0 && expected_draws.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
